// ===== hw/rtl/est_pkg.sv =====
// Shared types and constants for the entity slot table.
package est_pkg;

  typedef enum logic [2:0] {
    CMD_SPAWN   = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_FIRST   = 3'd2,
    CMD_NEXT    = 3'd3,
    CMD_GET     = 3'd4,
    CMD_MARK    = 3'd5
  } cmd_t;

  localparam int ID_W   = 9;
  localparam int KIND_W = 2;
  localparam int WORD_W = 32;
  localparam int REC_W  = 5 * WORD_W;

  // occupancy bitmap update request
  typedef struct packed {
    logic set_en;   // write set_val at the lowest free slot
    logic set_val;
    logic clr_en;   // clear the addressed slot
  } occ_upd_t;

  // occupancy scan status
  typedef struct packed {
    logic free_found;
    logic used_found;
    logic rd_occ;
  } occ_scan_t;

endpackage

// ===== hw/rtl/est_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module est_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== hw/rtl/est_occ.sv =====
// Occupancy bitmap with lowest-free and lowest-occupied priority encoders.
module est_occ #(
  parameter int SLOTS = 256,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  est_pkg::occ_upd_t        upd,
  input  logic [AW-1:0]            clr_idx,
  input  logic [est_pkg::ID_W-1:0] start_id,
  input  logic [AW-1:0]            rd_idx,
  output est_pkg::occ_scan_t       scan,
  output logic [AW-1:0]            free_idx,
  output logic [AW-1:0]            used_idx
);

  logic [SLOTS-1:0] occ_r;
  logic [SLOTS-1:0] occ_nxt;
  logic             free_found;
  logic             used_found;

  // bit j holds slot j+1; scan from the top so the lowest match wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    used_found = 1'b0;
    used_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!occ_r[j]) begin
        free_found = 1'b1;
        free_idx   = AW'(j);
      end
      if (occ_r[j] && (j >= int'(start_id))) begin
        used_found = 1'b1;
        used_idx   = AW'(j);
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (upd.set_en) begin
      occ_nxt[free_idx] = upd.set_val;
    end
    if (upd.clr_en) begin
      occ_nxt[clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign scan.free_found = free_found;
  assign scan.used_found = used_found;
  assign scan.rd_occ     = occ_r[rd_idx];

endmodule

// ===== hw/rtl/entity_slot_table.sv =====
// Entity slot table top level: command decode, occupancy, record and mark RAMs.
//
//  channel   handshake               fields
//  -------   ---------------------   -----------------------------------------
//  in        start & !busy           in_cmd, in_slot_id, in_kind_in, in_pos_*,
//                                    in_yaw_in, in_pitch_in
//  out       out_valid (one cycle)   out_result_slot, out_ok, out_full_res,
//                                    out_kind_out, out_pos_*, out_yaw_out,
//                                    out_pitch_out, out_changed_out
//
// One item per cycle; its result shows in the cycle after acceptance.
// Slot search is combinational over the occupancy flops; get reads the RAMs,
// whose read data is registered.
// busy is never raised. Synchronous reset clears the occupancy bitmap,
// which also masks the kind and changed mark of never-written slots.
module entity_slot_table #(
  parameter int SLOTS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_cmd,
  input  logic [est_pkg::ID_W-1:0]   in_slot_id,
  input  logic [est_pkg::KIND_W-1:0] in_kind_in,
  input  logic [est_pkg::WORD_W-1:0] in_pos_x_in,
  input  logic [est_pkg::WORD_W-1:0] in_pos_y_in,
  input  logic [est_pkg::WORD_W-1:0] in_pos_z_in,
  input  logic [est_pkg::WORD_W-1:0] in_yaw_in,
  input  logic [est_pkg::WORD_W-1:0] in_pitch_in,
  output logic                       out_valid,
  output logic [est_pkg::ID_W-1:0]   out_result_slot,
  output logic                       out_ok,
  output logic                       out_full_res,
  output logic [est_pkg::KIND_W-1:0] out_kind_out,
  output logic [est_pkg::WORD_W-1:0] out_pos_x_out,
  output logic [est_pkg::WORD_W-1:0] out_pos_y_out,
  output logic [est_pkg::WORD_W-1:0] out_pos_z_out,
  output logic [est_pkg::WORD_W-1:0] out_yaw_out,
  output logic [est_pkg::WORD_W-1:0] out_pitch_out,
  output logic                       out_changed_out
);

  localparam int AW    = $clog2(SLOTS);
  localparam int SW    = $clog2(SLOTS + 2);
  localparam int DAT_W = est_pkg::KIND_W + est_pkg::REC_W;

  logic                     acc;
  logic                     id_ok;
  logic [AW-1:0]            idx;
  logic [est_pkg::ID_W-1:0] start_id;
  est_pkg::occ_upd_t        upd;
  est_pkg::occ_scan_t       scan;
  logic [AW-1:0]            free_idx;
  logic [AW-1:0]            used_idx;
  logic [SW-1:0]            used_num;
  logic [SW-1:0]            free_num;

  logic                     rec_we;
  logic [DAT_W-1:0]         rec_wdata;
  logic [DAT_W-1:0]         rec_rdata;
  logic                     chg_we;
  logic                     chg_wdata;
  logic                     chg_rdata;
  logic [AW-1:0]            waddr;

  logic                     out_valid_r;
  logic [SW-1:0]            res_slot_r;
  logic [SW-1:0]            res_slot_nxt;
  logic                     ok_r;
  logic                     ok_nxt;
  logic                     full_r;
  logic                     full_nxt;
  logic                     get_r;
  logic                     get_nxt;
  logic                     occ_rd_r;

  assign busy  = 1'b0;
  assign acc   = start && !busy;
  assign id_ok = (in_slot_id != '0) && (32'(in_slot_id) <= SLOTS);
  assign idx   = AW'(in_slot_id - est_pkg::ID_W'(1));

  assign start_id = (est_pkg::cmd_t'(in_cmd) == est_pkg::CMD_FIRST) ? '0 : in_slot_id;
  assign used_num = scan.used_found ? (SW'(used_idx) + SW'(1)) : SW'(SLOTS + 1);
  assign free_num = SW'(free_idx) + SW'(1);

  assign waddr     = (est_pkg::cmd_t'(in_cmd) == est_pkg::CMD_SPAWN) ? free_idx : idx;
  assign rec_wdata = (est_pkg::cmd_t'(in_cmd) == est_pkg::CMD_SPAWN) ?
                     {in_kind_in, in_pitch_in, in_yaw_in, in_pos_z_in, in_pos_y_in,
                      in_pos_x_in} : '0;

  always_comb begin
    upd          = '0;
    rec_we       = 1'b0;
    chg_we       = 1'b0;
    chg_wdata    = 1'b0;
    res_slot_nxt = '0;
    ok_nxt       = 1'b0;
    full_nxt     = 1'b0;
    get_nxt      = 1'b0;
    if (acc) begin
      unique case (est_pkg::cmd_t'(in_cmd)) inside
        est_pkg::CMD_SPAWN: begin
          if (scan.free_found) begin
            upd.set_en   = 1'b1;
            upd.set_val  = (in_kind_in != '0);
            rec_we       = 1'b1;
            chg_we       = 1'b1;
            res_slot_nxt = free_num;
            ok_nxt       = 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end
        est_pkg::CMD_DESTROY: begin
          if (id_ok) begin
            upd.clr_en = 1'b1;
            rec_we     = 1'b1;
            chg_we     = 1'b1;
            ok_nxt     = 1'b1;
          end
        end
        est_pkg::CMD_FIRST, est_pkg::CMD_NEXT: begin
          res_slot_nxt = used_num;
          ok_nxt       = 1'b1;
        end
        est_pkg::CMD_GET: begin
          ok_nxt  = id_ok;
          get_nxt = id_ok;
        end
        est_pkg::CMD_MARK: begin
          if (id_ok && scan.rd_occ) begin
            chg_we    = 1'b1;
            chg_wdata = 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  est_occ #(
    .SLOTS(SLOTS)
  ) u_occ (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .clr_idx  (idx),
    .start_id (start_id),
    .rd_idx   (idx),
    .scan     (scan),
    .free_idx (free_idx),
    .used_idx (used_idx)
  );

  // kind and record words
  est_ram #(
    .W(DAT_W),
    .D(SLOTS)
  ) u_rec_ram (
    .clk     (clk),
    .we      (rec_we),
    .waddr   (waddr),
    .wdata   (rec_wdata),
    .raddr   (idx),
    .rdata_r (rec_rdata)
  );

  // changed marks
  est_ram #(
    .W(1),
    .D(SLOTS)
  ) u_chg_ram (
    .clk     (clk),
    .we      (chg_we),
    .waddr   (waddr),
    .wdata   (chg_wdata),
    .raddr   (idx),
    .rdata_r (chg_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    res_slot_r <= res_slot_nxt;
    ok_r       <= ok_nxt;
    full_r     <= full_nxt;
    get_r      <= get_nxt;
    occ_rd_r   <= scan.rd_occ;
  end

  // kind and mark of a free slot read as zero
  assign out_valid       = out_valid_r;
  assign out_result_slot = est_pkg::ID_W'(res_slot_r);
  assign out_ok          = ok_r;
  assign out_full_res    = full_r;
  assign out_kind_out    = (get_r && occ_rd_r) ? rec_rdata[DAT_W-1 -: est_pkg::KIND_W] : '0;
  assign out_pitch_out   = get_r ? rec_rdata[4*est_pkg::WORD_W +: est_pkg::WORD_W] : '0;
  assign out_yaw_out     = get_r ? rec_rdata[3*est_pkg::WORD_W +: est_pkg::WORD_W] : '0;
  assign out_pos_z_out   = get_r ? rec_rdata[2*est_pkg::WORD_W +: est_pkg::WORD_W] : '0;
  assign out_pos_y_out   = get_r ? rec_rdata[est_pkg::WORD_W +: est_pkg::WORD_W] : '0;
  assign out_pos_x_out   = get_r ? rec_rdata[0 +: est_pkg::WORD_W] : '0;
  assign out_changed_out = get_r && occ_rd_r && chg_rdata;

  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("result strobe missing after accepted item");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> !out_valid)
    else $error("result strobe without accepted item");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (est_pkg::cmd_t'(in_cmd) == est_pkg::CMD_SPAWN) && !scan.free_found) |=>
    (out_full_res && !out_ok && (out_result_slot == '0)))
    else $error("spawn into full table gave wrong result");

  a_mark_needs_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_changed_out) |-> (out_kind_out != '0))
    else $error("changed mark on a free slot");

endmodule

// ===== verif/entity_slot_table_tb.sv =====
// Self-checking testbench for entity_slot_table: directed and random commands against a slot model.
module entity_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import est_pkg::*;

  localparam int SLOTS = 256;
  localparam int NO_SLOT = SLOTS + 1;
  localparam int IDLE_LIMIT = 1000;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef logic [4:0][WORD_W-1:0] rec_words_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    rec_words_t        words;
  } slot_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   slot;
    logic              ok;
    logic              full;
    logic [KIND_W-1:0] kind;
    rec_words_t        words;
    logic              changed;
  } slot_res_t;

  class slot_table_scoreboard;
    logic [KIND_W-1:0] kind_of [1:SLOTS];
    logic              changed_of [1:SLOTS];
    rec_words_t        record_of [1:SLOTS];
    bit                written [1:SLOTS];
    int                written_ids[$];
    slot_res_t         awaited[$];
    int                errors;
    int                checked;
    int                full_hits;

    function new();
      for (int i = 1; i <= SLOTS; i++) begin
        kind_of[i] = '0;
        changed_of[i] = 1'b0;
        record_of[i] = '0;
        written[i] = 1'b0;
      end
      errors = 0;
      checked = 0;
      full_hits = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int i = 1; i <= SLOTS; i++) if (kind_of[i] != 0) n++;
      return n;
    endfunction

    function int lowest_used(int from);
      for (int i = from; i <= SLOTS; i++) if (kind_of[i] != 0) return i;
      return NO_SLOT;
    endfunction

    function void store(int s, logic [KIND_W-1:0] k, rec_words_t w);
      kind_of[s] = k;
      changed_of[s] = 1'b0;
      record_of[s] = w;
      if (!written[s]) written_ids.push_back(s);
      written[s] = 1'b1;
    endfunction

    function void note_item(slot_cmd_t it);
      slot_res_t r;
      int s;
      int id;
      bit in_range;
      r = '0;
      id = it.id;
      in_range = (id >= 1) && (id <= SLOTS);
      case (it.cmd)
        CMD_SPAWN: begin
          s = 1;
          while (s <= SLOTS && kind_of[s] != 0) s++;
          if (s > SLOTS) begin
            r.full = 1'b1;
          end else begin
            store(s, it.kind, it.words);
            r.slot = s[ID_W-1:0];
            r.ok = 1'b1;
          end
        end
        CMD_DESTROY: begin
          if (in_range) begin
            store(id, '0, '0);
            r.ok = 1'b1;
          end
        end
        CMD_FIRST: begin
          s = lowest_used(1);
          r.slot = s[ID_W-1:0];
          r.ok = 1'b1;
        end
        CMD_NEXT: begin
          s = lowest_used(id + 1);
          r.slot = s[ID_W-1:0];
          r.ok = 1'b1;
        end
        CMD_GET: begin
          if (in_range) begin
            r.ok = 1'b1;
            r.kind = kind_of[id];
            r.words = record_of[id];
            r.changed = changed_of[id];
          end
        end
        CMD_MARK: begin
          if (in_range && kind_of[id] != 0) begin
            changed_of[id] = 1'b1;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [WORD_W-1:0] e, logic [WORD_W-1:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t ERROR %s expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(slot_res_t got);
      slot_res_t e;
      string word_name[5];
      word_name = '{"pos_x", "pos_y", "pos_z", "yaw", "pitch"};
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result: expected none, actual slot %0d ok %0b",
                 $time, got.slot, got.ok);
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (e.full) full_hits++;
      compare("result_slot", e.slot, got.slot);
      compare("ok", e.ok, got.ok);
      compare("full_res", e.full, got.full);
      compare("kind_out", e.kind, got.kind);
      for (int k = 0; k < 5; k++) compare(word_name[k], e.words[k], got.words[k]);
      compare("changed_out", e.changed, got.changed);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_cmd = '0;
  logic [ID_W-1:0]   in_slot_id = '0;
  logic [KIND_W-1:0] in_kind_in = '0;
  logic [WORD_W-1:0] in_pos_x_in = '0;
  logic [WORD_W-1:0] in_pos_y_in = '0;
  logic [WORD_W-1:0] in_pos_z_in = '0;
  logic [WORD_W-1:0] in_yaw_in = '0;
  logic [WORD_W-1:0] in_pitch_in = '0;
  logic              out_valid;
  logic [ID_W-1:0]   out_result_slot;
  logic              out_ok;
  logic              out_full_res;
  logic [KIND_W-1:0] out_kind_out;
  logic [WORD_W-1:0] out_pos_x_out;
  logic [WORD_W-1:0] out_pos_y_out;
  logic [WORD_W-1:0] out_pos_z_out;
  logic [WORD_W-1:0] out_yaw_out;
  logic [WORD_W-1:0] out_pitch_out;
  logic              out_changed_out;

  slot_table_scoreboard sb;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  entity_slot_table #(.SLOTS(SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_slot_id      (in_slot_id),
    .in_kind_in      (in_kind_in),
    .in_pos_x_in     (in_pos_x_in),
    .in_pos_y_in     (in_pos_y_in),
    .in_pos_z_in     (in_pos_z_in),
    .in_yaw_in       (in_yaw_in),
    .in_pitch_in     (in_pitch_in),
    .out_valid       (out_valid),
    .out_result_slot (out_result_slot),
    .out_ok          (out_ok),
    .out_full_res    (out_full_res),
    .out_kind_out    (out_kind_out),
    .out_pos_x_out   (out_pos_x_out),
    .out_pos_y_out   (out_pos_y_out),
    .out_pos_z_out   (out_pos_z_out),
    .out_yaw_out     (out_yaw_out),
    .out_pitch_out   (out_pitch_out),
    .out_changed_out (out_changed_out)
  );

  always #1 clk = ~clk;

  // results first: a result always belongs to an item noted at an earlier edge
  always @(posedge clk) begin
    slot_cmd_t it;
    slot_res_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.slot = out_result_slot;
        got.ok = out_ok;
        got.full = out_full_res;
        got.kind = out_kind_out;
        got.words = {out_pitch_out, out_yaw_out, out_pos_z_out, out_pos_y_out, out_pos_x_out};
        got.changed = out_changed_out;
        sb.check_result(got);
      end
      if (start && !busy) begin
        it.cmd = in_cmd;
        it.id = in_slot_id;
        it.kind = in_kind_in;
        it.words = {in_pitch_in, in_yaw_in, in_pos_z_in, in_pos_y_in, in_pos_x_in};
        sb.note_item(it);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("entity_slot_table_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic rec_words_t rand_words();
    rec_words_t w;
    for (int k = 0; k < 5; k++) begin
      case ($urandom_range(0, 9))
        0: w[k] = '0;
        1: w[k] = '1;
        default: w[k] = $urandom;
      endcase
    end
    return w;
  endfunction

  function automatic slot_cmd_t make_item(logic [2:0] c, int id, logic [KIND_W-1:0] k,
                                          rec_words_t w);
    slot_cmd_t it;
    it.cmd = c;
    it.id = id[ID_W-1:0];
    it.kind = k;
    it.words = w;
    return it;
  endfunction

  function automatic int pick_id();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 511);
      1: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return SLOTS;
          2: return NO_SLOT;
          default: return 511;
        endcase
      end
      2, 3, 4: return $urandom_range(1, 32);
      default: return $urandom_range(1, SLOTS);
    endcase
  endfunction

  // only slots with a written record, or numbers outside the table
  function automatic int pick_get_id();
    if (sb.written_ids.size() == 0 || $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(NO_SLOT, 511);
    end
    return sb.written_ids[$urandom_range(0, sb.written_ids.size() - 1)];
  endfunction

  function automatic slot_cmd_t random_item(int spawn_pct, int destroy_pct);
    int r;
    logic [2:0] c;
    int id;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) == 0) ? 2'd0 : KIND_W'($urandom_range(1, 3));
    if (r < spawn_pct) begin
      c = CMD_SPAWN;
    end else if (r < spawn_pct + destroy_pct) begin
      c = CMD_DESTROY;
    end else begin
      case ($urandom_range(0, 19))
        0, 1: c = CMD_FIRST;
        2, 3, 4, 5: c = CMD_NEXT;
        6, 7, 8, 9, 10, 11: c = CMD_GET;
        12, 13, 14, 15, 16, 17: c = CMD_MARK;
        18: c = CMD_RSVD_6;
        default: c = CMD_RSVD_7;
      endcase
    end
    id = (c == CMD_GET) ? pick_get_id() : pick_id();
    return make_item(c, id, k, rand_words());
  endfunction

  task automatic send(slot_cmd_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= it.cmd;
    in_slot_id <= it.id;
    in_kind_in <= it.kind;
    {in_pitch_in, in_yaw_in, in_pos_z_in, in_pos_y_in, in_pos_x_in} <= it.words;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int count, int spawn_pct, int destroy_pct);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send(random_item(spawn_pct, destroy_pct));
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, out-of-range numbers, mark on a free slot
    send(make_item(CMD_FIRST, 0, 2'd0, '0));
    send(make_item(CMD_NEXT, 0, 2'd0, '0));
    send(make_item(CMD_GET, 0, 2'd0, '0));
    send(make_item(CMD_GET, NO_SLOT, 2'd0, '0));
    send(make_item(CMD_GET, 511, 2'd0, '0));
    send(make_item(CMD_DESTROY, 0, 2'd0, '0));
    send(make_item(CMD_DESTROY, 300, 2'd0, '0));
    send(make_item(CMD_MARK, 1, 2'd0, '0));
    send(make_item(CMD_MARK, 0, 2'd0, '0));
    // spawn extremes; kind none leaves the slot free, kind 3 occupies it
    send(make_item(CMD_SPAWN, 511, 2'd1, '1));
    send(make_item(CMD_SPAWN, 0, 2'd2, '0));
    send(make_item(CMD_SPAWN, 0, 2'd0, rand_words()));
    send(make_item(CMD_GET, 3, 2'd0, '0));
    send(make_item(CMD_FIRST, 0, 2'd0, '0));
    send(make_item(CMD_SPAWN, 0, 2'd3, rand_words()));
    send(make_item(CMD_MARK, 2, 2'd0, '0));
    send(make_item(CMD_GET, 2, 2'd0, '0));
    send(make_item(CMD_NEXT, 1, 2'd0, '0));
    send(make_item(CMD_NEXT, 3, 2'd0, '0));
    send(make_item(CMD_NEXT, SLOTS, 2'd0, '0));
    send(make_item(CMD_NEXT, 511, 2'd0, '0));
    send(make_item(CMD_DESTROY, 1, 2'd0, '0));
    send(make_item(CMD_GET, 1, 2'd0, '0));
    send(make_item(CMD_FIRST, 0, 2'd0, '0));
    send(make_item(CMD_RSVD_6, 0, 2'd0, '0));
    send(make_item(CMD_RSVD_7, 511, 2'd3, '1));

    random_phase(380, 55, 5);

    // fill the table, then spawn into a full table
    while (sb.used_count() < SLOTS)
      send(make_item(CMD_SPAWN, 0, KIND_W'($urandom_range(1, 3)), rand_words()));
    repeat (3) send(make_item(CMD_SPAWN, 0, KIND_W'($urandom_range(0, 3)), rand_words()));
    send(make_item(CMD_GET, SLOTS, 2'd0, '0));
    send(make_item(CMD_NEXT, SLOTS - 1, 2'd0, '0));
    send(make_item(CMD_MARK, SLOTS, 2'd0, '0));
    send(make_item(CMD_GET, SLOTS, 2'd0, '0));
    wait_drained();

    random_phase(250, 5, 10);
    random_phase(350, 20, 40);
    random_phase(300, 40, 20);

    wait_drained();
    repeat (4) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t ERROR %0d results still pending: expected 0 actual %0d",
               $time, sb.pending(), sb.pending());
    end
    $display("Sent %0d commands, checked %0d results, %0d spawns hit a full table",
             items_sent, sb.checked, sb.full_hits);
    $display("%0d slots received a record; %0d mismatches", sb.written_ids.size(), sb.errors);
    if (sb.errors == 0) begin
      $display("entity_slot_table_tb OK");
    end else begin
      $display("entity_slot_table_tb NOT OK");
    end
    $finish;
  end

endmodule
